>>> design/hsl_pkg.sv
// shared constants for the hsl to rgb duty pipeline
// no dependencies
package hsl_pkg;
  localparam int unsigned RgDutyBits   = 10;
  localparam int unsigned BlueDutyBits = 8;
  localparam int unsigned TFull        = 768;
  localparam int unsigned TSixth       = 128;
  localparam int unsigned THalf        = 384;
  localparam int unsigned TTwoThirds   = 512;
  localparam int unsigned TThird       = 256;
endpackage

>>> design/hsl_chan.sv
// one channel: hue ramp in a register stage, multiply, then channel value
// depends on hsl_pkg
module hsl_chan (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [9:0]  t_i,
  input  logic [16:0] p_i,
  input  logic [16:0] q_i,
  output logic [16:0] x_o
);
  import hsl_pkg::*;
  logic [1:0]  sel_q;
  logic [8:0]  k_q;
  logic [16:0] p_q, q_q;
  logic [16:0] d;
  logic [25:0] prod;
  logic [16:0] c;
  logic [16:0] x_q;

  // sel: 0 rising, 1 flat q, 2 falling, 3 flat p
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_i;
      q_q <= q_i;
      if (t_i < 10'(TSixth)) begin
        sel_q <= 2'd0;
        k_q   <= 9'(t_i);
      end else if (t_i < 10'(THalf)) begin
        sel_q <= 2'd1;
        k_q   <= '0;
      end else if (t_i < 10'(TTwoThirds)) begin
        sel_q <= 2'd2;
        k_q   <= 9'(10'(TTwoThirds) - t_i);
      end else begin
        sel_q <= 2'd3;
        k_q   <= '0;
      end
    end
  end

  assign d    = q_q - p_q;
  assign prod = d * k_q;

  always_comb begin
    unique case (sel_q)
      2'd1:    c = q_q;
      2'd3:    c = p_q;
      default: c = p_q + prod[23:7];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) x_q <= 17'h10000 - c;
  end
  assign x_o = x_q;
endmodule

>>> design/hsl_sqrt.sv
// pipelined restoring square root, one result bit per stage, minus one with floor at zero
// depends on hsl_pkg
module hsl_sqrt #(
  parameter int unsigned Bits = hsl_pkg::RgDutyBits
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [16:0]     x_i,
  output logic [Bits-1:0] duty_o
);
  import hsl_pkg::*;
  localparam int unsigned RadW = 2 * Bits + 2;
  localparam int unsigned N    = Bits + 1;
  logic [RadW-1:0] rad_q [N+1];
  logic [RadW-1:0] rem_q [N+1];
  logic [N-1:0]    root_q [N+1];

  always_comb begin
    rad_q[0]  = RadW'(x_i) << (2 * Bits - 16);
    rem_q[0]  = '0;
    root_q[0] = '0;
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    logic [RadW-1:0] r, tr;
    always_comb begin
      r  = RadW'({rem_q[g], rad_q[g][RadW-1 -: 2]});
      tr = RadW'({root_q[g], 2'b01});
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g+1] <= rad_q[g] << 2;
        if (r >= tr) begin
          rem_q[g+1]  <= r - tr;
          root_q[g+1] <= {root_q[g][N-2:0], 1'b1};
        end else begin
          rem_q[g+1]  <= r;
          root_q[g+1] <= {root_q[g][N-2:0], 1'b0};
        end
      end
    end
  end

  logic [N-1:0] dm;
  assign dm     = (root_q[N] != '0) ? root_q[N] - 1'b1 : '0;
  assign duty_o = dm[Bits-1:0];
endmodule

>>> design/hsl_to_rgb_pwm_duty.sv
// hsl to rgb inverted square-root pwm duty, fully pipelined
// stages: input, q/p, ramp select and channel value, then one root bit per stage
// throughput: one transfer per cycle; a stall freezes every stage together
// reset clears the valid bits only; depends on hsl_pkg, hsl_chan, hsl_sqrt
module hsl_to_rgb_pwm_duty #(
  parameter int unsigned RG_DUTY_BITS   = hsl_pkg::RgDutyBits,
  parameter int unsigned BLUE_DUTY_BITS = hsl_pkg::BlueDutyBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [7:0]                hue_i,
  input  logic [7:0]                saturation_i,
  input  logic [7:0]                lightness_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [RG_DUTY_BITS-1:0]   red_duty_o,
  output logic [RG_DUTY_BITS-1:0]   green_duty_o,
  output logic [BLUE_DUTY_BITS-1:0] blue_duty_o
);
  import hsl_pkg::*;
  localparam int unsigned MaxB = (RG_DUTY_BITS > BLUE_DUTY_BITS) ?
                                 RG_DUTY_BITS : BLUE_DUTY_BITS;
  localparam int unsigned Lat  = 4 + MaxB + 1;

  logic en;
  logic [Lat-1:0] vld_q;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  // stage 0: q and p
  logic [7:0]  h_q, s_q, l_q;
  logic [16:0] q, p;
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q <= hue_i;
      s_q <= saturation_i;
      l_q <= lightness_i;
    end
  end
  always_comb begin
    if (l_q < 8'd128) q = 17'(l_q * (9'd256 + s_q));
    else              q = 17'(({l_q, 8'h0} + {s_q, 8'h0}) - l_q * s_q);
    p = 17'({l_q, 9'h0}) - q;
  end

  logic [9:0] th, tr, tb;
  always_comb begin
    th = 10'(3 * h_q);
    tr = th + 10'(TThird);
    if (tr >= 10'(TFull)) tr = tr - 10'(TFull);
    tb = (th < 10'(TThird)) ? th + 10'(TFull - TThird) : th - 10'(TThird);
  end

  logic [16:0] p_q, q_q;
  logic [9:0]  tr_q, tg_q, tb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p; q_q <= q;
      tr_q <= tr; tg_q <= th; tb_q <= tb;
    end
  end

  logic [16:0] xr, xg, xb;
  hsl_chan u_r (.clk_i, .en_i(en), .t_i(tr_q), .p_i(p_q), .q_i(q_q), .x_o(xr));
  hsl_chan u_g (.clk_i, .en_i(en), .t_i(tg_q), .p_i(p_q), .q_i(q_q), .x_o(xg));
  hsl_chan u_b (.clk_i, .en_i(en), .t_i(tb_q), .p_i(p_q), .q_i(q_q), .x_o(xb));

  // align the shorter root with delay stages so all finish together
  localparam int unsigned PadR = MaxB - RG_DUTY_BITS;
  localparam int unsigned PadB = MaxB - BLUE_DUTY_BITS;
  logic [16:0] xr_d [PadR+1];
  logic [16:0] xg_d [PadR+1];
  logic [16:0] xb_d [PadB+1];
  assign xr_d[0] = xr;
  assign xg_d[0] = xg;
  assign xb_d[0] = xb;
  for (genvar i = 0; i < PadR; i++) begin : g_pr
    always_ff @(posedge clk_i) if (en) begin
      xr_d[i+1] <= xr_d[i];
      xg_d[i+1] <= xg_d[i];
    end
  end
  for (genvar i = 0; i < PadB; i++) begin : g_pb
    always_ff @(posedge clk_i) if (en) xb_d[i+1] <= xb_d[i];
  end

  hsl_sqrt #(.Bits(RG_DUTY_BITS)) u_sr (
    .clk_i, .en_i(en), .x_i(xr_d[PadR]), .duty_o(red_duty_o));
  hsl_sqrt #(.Bits(RG_DUTY_BITS)) u_sg (
    .clk_i, .en_i(en), .x_i(xg_d[PadR]), .duty_o(green_duty_o));
  hsl_sqrt #(.Bits(BLUE_DUTY_BITS)) u_sb (
    .clk_i, .en_i(en), .x_i(xb_d[PadB]), .duty_o(blue_duty_o));
endmodule
